[rtl/tcac_pkg.sv]
// shared types and constants for the triangle coverage average color block
// no dependencies; imported by every module of the block
package tcac_pkg;

	localparam int MAX_DIM     = 1024;
	localparam int CNT_CAP     = MAX_DIM * MAX_DIM;
	localparam int QUEUE_DEPTH = 2;

	localparam int VTX_W     = 11;
	localparam int PIX_W     = 10;
	localparam int COL_W     = 8;
	localparam int SUM_W     = 28;
	localparam int CNT_W     = 21;
	localparam int CFG_IDX_W = 3;
	localparam int LANES     = 3;

	// arithmetic widths of the inside test
	localparam int DIF_W = VTX_W + 1;
	localparam int PRD_W = 2 * DIF_W;
	localparam int DOT_W = PRD_W + 1;
	localparam int MUL_W = 2 * DOT_W;
	localparam int BIG_W = MUL_W + 1;
	localparam int CHK_W = BIG_W + 1;

	localparam int STEP_W = $clog2(COL_W);

	localparam logic [COL_W-1:0] WHITE = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_V0X,
		REG_V0Y,
		REG_V1X,
		REG_V1Y,
		REG_V2X,
		REG_V2Y
	} cfg_reg_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum_red;
		logic [SUM_W-1:0] sum_green;
		logic [SUM_W-1:0] sum_blue;
		logic [CNT_W-1:0] count;
	} acc_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_HOLD
	} div_state_t;

endpackage

[rtl/tcac_front.sv]
// front end: vertex registers, pipelined exact barycentric inside test, accumulators
// depends on tcac_pkg; pushes one accumulator snapshot per image
module tcac_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tcac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcac_pkg::VTX_W-1:0]     cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic [tcac_pkg::PIX_W-1:0]     pixel_x,
	input  logic [tcac_pkg::PIX_W-1:0]     pixel_y,
	input  logic [tcac_pkg::COL_W-1:0]     pixel_red,
	input  logic [tcac_pkg::COL_W-1:0]     pixel_green,
	input  logic [tcac_pkg::COL_W-1:0]     pixel_blue,
	input  logic                          last_pixel,
	output logic                          acc_push,
	output tcac_pkg::acc_t                acc_data,
	input  logic                          acc_full
);
	import tcac_pkg::*;

	logic [VTX_W-1:0] v0x_q, v0y_q, v1x_q, v1y_q, v2x_q, v2y_q;

	logic adv, accept;

	logic signed [DIF_W-1:0] ax_c, ay_c, bx_c, by_c, qx_c, qy_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [COL_W-1:0] red_s1, red_s2, red_s3, red_s4, red_s5, red_s6;
	logic [COL_W-1:0] green_s1, green_s2, green_s3, green_s4, green_s5, green_s6;
	logic [COL_W-1:0] blue_s1, blue_s2, blue_s3, blue_s4, blue_s5, blue_s6;

	logic signed [DIF_W-1:0] ax_s1, ay_s1, bx_s1, by_s1, qx_s1, qy_s1;
	logic signed [PRD_W-1:0] p_axax_s2, p_ayay_s2, p_axbx_s2, p_ayby_s2, p_bxbx_s2;
	logic signed [PRD_W-1:0] p_byby_s2, p_qxax_s2, p_qyay_s2, p_qxbx_s2, p_qyby_s2;
	logic signed [DOT_W-1:0] d00_s3, d01_s3, d11_s3, d20_s3, d21_s3;
	logic signed [MUL_W-1:0] m_den_a_s4, m_den_b_s4, m_nv_a_s4, m_nv_b_s4;
	logic signed [MUL_W-1:0] m_nw_a_s4, m_nw_b_s4;
	logic signed [BIG_W-1:0] den_s5, nv_s5, nw_s5;
	logic                    covered_s6;

	logic signed [CHK_W-1:0] vw_c;
	logic                    covered_c;

	logic [SUM_W-1:0] sum_red_q, sum_green_q, sum_blue_q;
	logic [CNT_W-1:0] cnt_q;
	logic             inc;
	acc_t             nxt;

	// vertex registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0x_q <= '0;
			v0y_q <= '0;
			v1x_q <= '0;
			v1y_q <= '0;
			v2x_q <= '0;
			v2y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_V0X: v0x_q <= cfg_data;
				REG_V0Y: v0y_q <= cfg_data;
				REG_V1X: v1x_q <= cfg_data;
				REG_V1Y: v1y_q <= cfg_data;
				REG_V2X: v2x_q <= cfg_data;
				REG_V2Y: v2y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline holds while a finished image waits for queue space
	assign adv    = !(v_s6 && last_s6 && acc_full);
	assign full   = !adv;
	assign accept = push && adv;

	assign ax_c = $signed({1'b0, v2x_q}) - $signed({1'b0, v0x_q});
	assign ay_c = $signed({1'b0, v2y_q}) - $signed({1'b0, v0y_q});
	assign bx_c = $signed({1'b0, v1x_q}) - $signed({1'b0, v0x_q});
	assign by_c = $signed({1'b0, v1y_q}) - $signed({1'b0, v0y_q});
	assign qx_c = $signed({2'b00, pixel_x}) - $signed({1'b0, v0x_q});
	assign qy_c = $signed({2'b00, pixel_y}) - $signed({1'b0, v0y_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1    <= ax_c;
			ay_s1    <= ay_c;
			bx_s1    <= bx_c;
			by_s1    <= by_c;
			qx_s1    <= qx_c;
			qy_s1    <= qy_c;
			red_s1   <= pixel_red;
			green_s1 <= pixel_green;
			blue_s1  <= pixel_blue;
			last_s1  <= last_pixel;

			p_axax_s2 <= PRD_W'(ax_s1) * PRD_W'(ax_s1);
			p_ayay_s2 <= PRD_W'(ay_s1) * PRD_W'(ay_s1);
			p_axbx_s2 <= PRD_W'(ax_s1) * PRD_W'(bx_s1);
			p_ayby_s2 <= PRD_W'(ay_s1) * PRD_W'(by_s1);
			p_bxbx_s2 <= PRD_W'(bx_s1) * PRD_W'(bx_s1);
			p_byby_s2 <= PRD_W'(by_s1) * PRD_W'(by_s1);
			p_qxax_s2 <= PRD_W'(qx_s1) * PRD_W'(ax_s1);
			p_qyay_s2 <= PRD_W'(qy_s1) * PRD_W'(ay_s1);
			p_qxbx_s2 <= PRD_W'(qx_s1) * PRD_W'(bx_s1);
			p_qyby_s2 <= PRD_W'(qy_s1) * PRD_W'(by_s1);
			red_s2    <= red_s1;
			green_s2  <= green_s1;
			blue_s2   <= blue_s1;
			last_s2   <= last_s1;

			d00_s3   <= DOT_W'(p_axax_s2) + DOT_W'(p_ayay_s2);
			d01_s3   <= DOT_W'(p_axbx_s2) + DOT_W'(p_ayby_s2);
			d11_s3   <= DOT_W'(p_bxbx_s2) + DOT_W'(p_byby_s2);
			d20_s3   <= DOT_W'(p_qxax_s2) + DOT_W'(p_qyay_s2);
			d21_s3   <= DOT_W'(p_qxbx_s2) + DOT_W'(p_qyby_s2);
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
			last_s3  <= last_s2;

			m_den_a_s4 <= MUL_W'(d00_s3) * MUL_W'(d11_s3);
			m_den_b_s4 <= MUL_W'(d01_s3) * MUL_W'(d01_s3);
			m_nv_a_s4  <= MUL_W'(d11_s3) * MUL_W'(d20_s3);
			m_nv_b_s4  <= MUL_W'(d01_s3) * MUL_W'(d21_s3);
			m_nw_a_s4  <= MUL_W'(d00_s3) * MUL_W'(d21_s3);
			m_nw_b_s4  <= MUL_W'(d01_s3) * MUL_W'(d20_s3);
			red_s4     <= red_s3;
			green_s4   <= green_s3;
			blue_s4    <= blue_s3;
			last_s4    <= last_s3;

			den_s5   <= BIG_W'(m_den_a_s4) - BIG_W'(m_den_b_s4);
			nv_s5    <= BIG_W'(m_nv_a_s4) - BIG_W'(m_nv_b_s4);
			nw_s5    <= BIG_W'(m_nw_a_s4) - BIG_W'(m_nw_b_s4);
			red_s5   <= red_s4;
			green_s5 <= green_s4;
			blue_s5  <= blue_s4;
			last_s5  <= last_s4;

			covered_s6 <= covered_c;
			red_s6     <= red_s5;
			green_s6   <= green_s5;
			blue_s6    <= blue_s5;
			last_s6    <= last_s5;
		end
	end

	// degenerate triangle (den not positive) covers nothing; boundary counts as inside
	assign vw_c      = CHK_W'(nv_s5) + CHK_W'(nw_s5);
	assign covered_c = (den_s5 > 0) && (nv_s5 >= 0) && (nw_s5 >= 0)
		&& (vw_c <= CHK_W'(den_s5));

	// count saturates at the cap, further covered pixels are dropped
	assign inc = v_s6 && covered_s6 && (cnt_q < CNT_W'(CNT_CAP));

	always_comb begin
		nxt.sum_red   = sum_red_q;
		nxt.sum_green = sum_green_q;
		nxt.sum_blue  = sum_blue_q;
		nxt.count     = cnt_q;
		if (inc) begin
			nxt.sum_red   = sum_red_q + SUM_W'(red_s6);
			nxt.sum_green = sum_green_q + SUM_W'(green_s6);
			nxt.sum_blue  = sum_blue_q + SUM_W'(blue_s6);
			nxt.count     = cnt_q + CNT_W'(1);
		end
	end

	assign acc_push = v_s6 && last_s6 && !acc_full;
	assign acc_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_red_q   <= '0;
			sum_green_q <= '0;
			sum_blue_q  <= '0;
			cnt_q       <= '0;
		end else if (adv && v_s6) begin
			if (last_s6) begin
				sum_red_q   <= '0;
				sum_green_q <= '0;
				sum_blue_q  <= '0;
				cnt_q       <= '0;
			end else begin
				sum_red_q   <= nxt.sum_red;
				sum_green_q <= nxt.sum_green;
				sum_blue_q  <= nxt.sum_blue;
				cnt_q       <= nxt.count;
			end
		end
	end

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CNT_CAP))
		else $error("covered count beyond cap");

endmodule

[rtl/tcac_queue.sv]
// short queue of per-image accumulator snapshots between front and back end
// depends on tcac_pkg for the entry type
module tcac_queue #(
	parameter int DEPTH = tcac_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  tcac_pkg::acc_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output tcac_pkg::acc_t rd_data,
	output logic           empty
);
	import tcac_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);

	acc_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OCC_W-1:0] occ_q;

	assign full    = (occ_q == OCC_W'(DEPTH));
	assign empty   = (occ_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (rd_en && !wr_en) begin
				occ_q <= occ_q - OCC_W'(1);
			end
		end
	end

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("queue occupancy out of range");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with mismatched pointers");

endmodule

[rtl/tcac_divider.sv]
// back end: restoring divider, one quotient bit per cycle on three color lanes
// depends on tcac_pkg; holds the result in an output register until popped
module tcac_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  tcac_pkg::acc_t            q_data,
	output logic                      q_pop,
	output logic [tcac_pkg::COL_W-1:0] avg_red,
	output logic [tcac_pkg::COL_W-1:0] avg_green,
	output logic [tcac_pkg::COL_W-1:0] avg_blue,
	output logic [tcac_pkg::CNT_W-1:0] covered_count,
	output logic                      none_covered,
	output logic                      empty,
	input  logic                      pop
);
	import tcac_pkg::*;

	div_state_t state_q, state_d;

	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  rem_q [LANES];
	logic [COL_W-1:0]  quo_q [LANES];
	logic [CNT_W-1:0]  div_q;

	logic [SUM_W-1:0] shifted;
	logic [SUM_W-1:0] rem_sub [LANES];
	logic             ge [LANES];

	logic             res_v_q;
	logic             res_free, load, zero;
	logic [COL_W-1:0] avg_red_q, avg_green_q, avg_blue_q;
	logic [CNT_W-1:0] count_q;
	logic             none_q;

	// quotient fits 8 bits since every sum is at most 255 times the count
	assign shifted = SUM_W'(div_q) << step_q;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			ge[i]      = (rem_q[i] >= shifted);
			rem_sub[i] = rem_q[i] - shifted;
		end
	end

	assign res_free = !res_v_q || pop;
	assign load     = (state_q == DIV_HOLD) && res_free;
	assign q_pop    = (state_q == DIV_IDLE) && !q_empty;
	assign zero     = (div_q == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: if (!q_empty) state_d = DIV_RUN;
			DIV_RUN:  if (step_q == '0) state_d = DIV_HOLD;
			DIV_HOLD: if (res_free) state_d = DIV_IDLE;
			default:  state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				res_v_q <= 1'b1;
			end else if (pop) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rem_q[0] <= q_data.sum_red;
			rem_q[1] <= q_data.sum_green;
			rem_q[2] <= q_data.sum_blue;
			div_q    <= q_data.count;
			step_q   <= STEP_W'(COL_W - 1);
			for (int i = 0; i < LANES; i++) begin
				quo_q[i] <= '0;
			end
		end else if (state_q == DIV_RUN) begin
			for (int i = 0; i < LANES; i++) begin
				if (ge[i]) begin
					rem_q[i] <= rem_sub[i];
				end
				quo_q[i][step_q] <= ge[i];
			end
			step_q <= step_q - STEP_W'(1);
		end
		if (load) begin
			avg_red_q   <= zero ? WHITE : quo_q[0];
			avg_green_q <= zero ? WHITE : quo_q[1];
			avg_blue_q  <= zero ? WHITE : quo_q[2];
			count_q     <= div_q;
			none_q      <= zero;
		end
	end

	assign avg_red       = avg_red_q;
	assign avg_green     = avg_green_q;
	assign avg_blue      = avg_blue_q;
	assign covered_count = count_q;
	assign none_covered  = none_q;
	assign empty         = !res_v_q;

	a_load_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_v_q) |-> $past(state_q) == DIV_HOLD)
		else $error("result loaded outside hold state");

	a_empty_white: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && none_q) |-> (count_q == '0 && avg_red_q == WHITE
			&& avg_green_q == WHITE && avg_blue_q == WHITE))
		else $error("empty coverage result not white");

endmodule

[rtl/triangle_coverage_average_color.sv]
// top level of the triangle coverage average color block
// depends on tcac_pkg, tcac_front, tcac_queue and tcac_divider
//
// Pixels stream in at one per cycle and are tested against the triangle held in
// the six vertex registers with an exact integer barycentric test (edges count as
// inside, a degenerate triangle covers nothing). Covered pixels add to per-channel
// sums and a count; the pixel flagged last_pixel closes the image and one result
// comes out: the truncated channel means and the count, or white with
// none_covered set when nothing was covered. The inside test is a six-stage
// pipeline; after the edge that accepts the last pixel of an image, its result
// passes five more test stages, the accumulate and queue write, the divider
// pickup, the eight quotient steps of the bit-per-cycle divider and the load of
// the output register before it reaches the output ports. The divider handles
// one image at a time; pixel intake continues while it runs, and stalls
// (full high) only when the snapshot queue in front of the divider is full and
// another image ends. The user writes the vertex registers only while no image
// is in flight; the block itself does not enforce this.
module triangle_coverage_average_color #(
	parameter int QUEUE_DEPTH = tcac_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tcac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcac_pkg::VTX_W-1:0]     cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic [tcac_pkg::PIX_W-1:0]     pixel_x,
	input  logic [tcac_pkg::PIX_W-1:0]     pixel_y,
	input  logic [tcac_pkg::COL_W-1:0]     pixel_red,
	input  logic [tcac_pkg::COL_W-1:0]     pixel_green,
	input  logic [tcac_pkg::COL_W-1:0]     pixel_blue,
	input  logic                          last_pixel,
	output logic                          empty,
	input  logic                          pop,
	output logic [tcac_pkg::COL_W-1:0]     avg_red,
	output logic [tcac_pkg::COL_W-1:0]     avg_green,
	output logic [tcac_pkg::COL_W-1:0]     avg_blue,
	output logic [tcac_pkg::CNT_W-1:0]     covered_count,
	output logic                          none_covered
);
	import tcac_pkg::*;

	logic acc_push, acc_full, acc_pop, acc_empty;
	acc_t acc_wr, acc_rd;

	tcac_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.last_pixel  (last_pixel),
		.acc_push    (acc_push),
		.acc_data    (acc_wr),
		.acc_full    (acc_full)
	);

	tcac_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (acc_push),
		.wr_data (acc_wr),
		.full    (acc_full),
		.rd_en   (acc_pop),
		.rd_data (acc_rd),
		.empty   (acc_empty)
	);

	tcac_divider u_divider (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (acc_empty),
		.q_data        (acc_rd),
		.q_pop         (acc_pop),
		.avg_red       (avg_red),
		.avg_green     (avg_green),
		.avg_blue      (avg_blue),
		.covered_count (covered_count),
		.none_covered  (none_covered),
		.empty         (empty),
		.pop           (pop)
	);

endmodule

[tb/sv/triangle_coverage_average_color_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the triangle coverage average color block
// depends on tcac_pkg and triangle_coverage_average_color; predicts each image average itself

module triangle_coverage_average_color_tb;

	import tcac_pkg::*;

	localparam int N_VTX_REGS     = int'(REG_V2Y) + 1;
	localparam int PIX_MAX        = 2 ** PIX_W - 1;
	localparam int VTX_MAX        = 2 ** VTX_W - 1;
	localparam int N_SHAPES       = 6;
	localparam int N_DIR          = 17;
	localparam int DRAIN_CYCLES   = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int N_PHASES       = 12;
	localparam int PHASE_ITEMS    = 100;
	localparam int PRESSURE_ITEMS = 80;

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
		logic             last;
	} pixel_t;

	typedef struct packed {
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
		logic [CNT_W-1:0] count;
		logic             none;
	} avg_t;

	// one triangle, registers in index order
	typedef logic [0:N_VTX_REGS-1][VTX_W-1:0] shape_t;

	typedef struct packed {
		int     shape_sel;
		pixel_t pix;
		logic   typed;
		avg_t   want;
	} dir_row_t;

	localparam avg_t WHITE_EMPTY = '{WHITE, WHITE, WHITE, '0, 1'b1};

	localparam shape_t DIR_SHAPES [N_SHAPES] = '{
		'{0, 0, 0, 0, 0, 0},                   // reset state, all vertices coincide
		'{0, 0, 1023, 0, 0, 1023},             // right triangle x + y <= 1023
		'{2047, 0, 0, 0, 0, 2047},             // vertices off the image, covers all of it
		'{0, 0, 10, 10, 20, 20},               // collinear
		'{2047, 2047, 1024, 2047, 2047, 1024}, // entirely off the image
		'{0, 0, 0, 1023, 1023, 0}              // right triangle, other winding
	};

	localparam dir_row_t DIRECTED [N_DIR] = '{
		'{0, '{0, 0, 255, 255, 255, 1}, 1, WHITE_EMPTY},
		'{0, '{1023, 1023, 0, 0, 0, 1}, 1, WHITE_EMPTY},
		'{1, '{0, 0, 255, 255, 255, 0}, 0, '0},
		'{1, '{1023, 0, 0, 0, 0, 0}, 0, '0},
		'{1, '{0, 1023, 255, 0, 128, 0}, 0, '0},
		'{1, '{512, 511, 1, 2, 3, 0}, 0, '0},
		'{1, '{512, 512, 200, 200, 200, 0}, 0, '0},
		'{1, '{1023, 1023, 9, 9, 9, 1}, 1, '{127, 64, 96, 4, 0}},
		'{1, '{100, 100, 255, 255, 255, 1}, 1, '{255, 255, 255, 1, 0}},
		'{1, '{1023, 1023, 0, 0, 0, 1}, 1, WHITE_EMPTY},
		'{1, '{0, 0, 0, 0, 0, 1}, 1, '{0, 0, 0, 1, 0}},
		'{2, '{1023, 1023, 17, 34, 51, 0}, 0, '0},
		'{2, '{0, 0, 255, 0, 255, 0}, 0, '0},
		'{2, '{345, 678, 128, 64, 32, 1}, 0, '0},
		'{3, '{10, 10, 255, 255, 255, 1}, 1, WHITE_EMPTY},
		'{4, '{1023, 1023, 255, 255, 255, 1}, 1, WHITE_EMPTY},
		'{5, '{512, 511, 1, 2, 3, 1}, 1, '{1, 2, 3, 1, 0}}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VTX_W-1:0]     cfg_data;
	logic                 push;
	logic                 full;
	logic [PIX_W-1:0]     pixel_x;
	logic [PIX_W-1:0]     pixel_y;
	logic [COL_W-1:0]     pixel_red;
	logic [COL_W-1:0]     pixel_green;
	logic [COL_W-1:0]     pixel_blue;
	logic                 last_pixel;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [COL_W-1:0]     avg_red;
	logic [COL_W-1:0]     avg_green;
	logic [COL_W-1:0]     avg_blue;
	logic [CNT_W-1:0]     covered_count;
	logic                 none_covered;

	// predictor copy of the vertex registers and the accumulators
	shape_t           shape_vtx = '0;
	logic [SUM_W-1:0] acc_red = '0;
	logic [SUM_W-1:0] acc_green = '0;
	logic [SUM_W-1:0] acc_blue = '0;
	logic [CNT_W-1:0] acc_count = '0;

	avg_t expected_avgs [$];

	int errors = 0;
	int pixels_sent = 0;
	int averages_checked = 0;
	int shapes_loaded = 0;
	int send_idle_pct = 36;
	int recv_idle_pct = 45;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int cur_shape;

	triangle_coverage_average_color dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// exact barycentric inside test, edges included
	function automatic bit pixel_inside(pixel_t p);
		longint ax, ay, bx, by, qx, qy;
		longint d00, d01, d11, d20, d21, den, nv, nw;
		ax = longint'(shape_vtx[REG_V2X]) - longint'(shape_vtx[REG_V0X]);
		ay = longint'(shape_vtx[REG_V2Y]) - longint'(shape_vtx[REG_V0Y]);
		bx = longint'(shape_vtx[REG_V1X]) - longint'(shape_vtx[REG_V0X]);
		by = longint'(shape_vtx[REG_V1Y]) - longint'(shape_vtx[REG_V0Y]);
		qx = longint'(p.x) - longint'(shape_vtx[REG_V0X]);
		qy = longint'(p.y) - longint'(shape_vtx[REG_V0Y]);
		d00 = ax * ax + ay * ay;
		d01 = ax * bx + ay * by;
		d11 = bx * bx + by * by;
		d20 = qx * ax + qy * ay;
		d21 = qx * bx + qy * by;
		den = d00 * d11 - d01 * d01;
		if (den <= 0)
			return 1'b0;
		nv = d11 * d20 - d01 * d21;
		nw = d00 * d21 - d01 * d20;
		return nv >= 0 && nw >= 0 && nv + nw <= den;
	endfunction

	function automatic void absorb_pixel(pixel_t p, output bit closed, output avg_t res);
		closed = p.last;
		res = WHITE_EMPTY;
		if (pixel_inside(p) && acc_count < CNT_CAP) begin
			acc_red += p.red;
			acc_green += p.green;
			acc_blue += p.blue;
			acc_count += 1'b1;
		end
		if (p.last) begin
			if (acc_count != 0) begin
				res.red = acc_red / acc_count;
				res.green = acc_green / acc_count;
				res.blue = acc_blue / acc_count;
				res.count = acc_count;
				res.none = 1'b0;
			end
			acc_red = '0;
			acc_green = '0;
			acc_blue = '0;
			acc_count = '0;
		end
	endfunction

	function automatic int clamp_vtx(int v);
		if (v < 0)
			return 0;
		if (v > VTX_MAX)
			return VTX_MAX;
		return v;
	endfunction

	function automatic shape_t random_shape();
		shape_t s;
		int kind, bx, by;
		kind = $urandom_range(7);
		bx = $urandom_range(PIX_MAX);
		by = $urandom_range(PIX_MAX);
		case (kind)
			0: for (int i = 0; i < N_VTX_REGS; i++) s[i] = $urandom_range(VTX_MAX);
			1: for (int i = 0; i < N_VTX_REGS; i++) s[i] = $urandom_range(PIX_MAX);
			2: begin
				for (int i = 0; i < N_VTX_REGS; i++) s[i] = $urandom_range(VTX_MAX);
				// third vertex on top of one of the others
				if ($urandom_range(1)) begin
					s[REG_V2X] = s[REG_V0X];
					s[REG_V2Y] = s[REG_V0Y];
				end else begin
					s[REG_V2X] = s[REG_V1X];
					s[REG_V2Y] = s[REG_V1Y];
				end
			end
			3: for (int i = 0; i < N_VTX_REGS; i++)
				case ($urandom_range(3))
					0: s[i] = 0;
					1: s[i] = PIX_MAX;
					2: s[i] = PIX_MAX + 1;
					default: s[i] = VTX_MAX;
				endcase
			default: begin
				// small triangle, so that a fair share of nearby pixels lands inside
				s[REG_V0X] = bx;
				s[REG_V0Y] = by;
				for (int i = int'(REG_V1X); i < N_VTX_REGS; i++)
					s[i] = clamp_vtx(((i % 2) ? by : bx) + int'($urandom_range(80)) - 40);
			end
		endcase
		return s;
	endfunction

	function automatic logic [COL_W-1:0] random_channel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom_range(2 ** COL_W - 1);
		endcase
	endfunction

	// mostly aim at the triangle's bounding box, else anywhere on the image
	function automatic pixel_t random_pixel(logic last);
		pixel_t p;
		int lo_x, hi_x, lo_y, hi_y, vx, vy;
		lo_x = VTX_MAX;
		lo_y = VTX_MAX;
		hi_x = 0;
		hi_y = 0;
		for (int k = 0; k < 3; k++) begin
			vx = shape_vtx[2 * k];
			vy = shape_vtx[2 * k + 1];
			if (vx < lo_x) lo_x = vx;
			if (vx > hi_x) hi_x = vx;
			if (vy < lo_y) lo_y = vy;
			if (vy > hi_y) hi_y = vy;
		end
		if (hi_x > PIX_MAX) hi_x = PIX_MAX;
		if (hi_y > PIX_MAX) hi_y = PIX_MAX;
		if ($urandom_range(9) < 7 && lo_x <= PIX_MAX && lo_y <= PIX_MAX) begin
			p.x = $urandom_range(hi_x, lo_x);
			p.y = $urandom_range(hi_y, lo_y);
		end else begin
			p.x = $urandom_range(PIX_MAX);
			p.y = $urandom_range(PIX_MAX);
		end
		p.red = random_channel();
		p.green = random_channel();
		p.blue = random_channel();
		p.last = last;
		return p;
	endfunction

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [VTX_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx <= REG_V2Y)
			shape_vtx[idx] = data;
	endtask

	task automatic load_shape(shape_t s);
		for (int i = 0; i < N_VTX_REGS; i++)
			cfg_write(i, s[i]);
		// indexes past the register list must leave the triangle alone
		for (int i = N_VTX_REGS; i < 2 ** CFG_IDX_W; i++)
			cfg_write(i, $urandom_range(VTX_MAX));
		cfg_we <= 1'b0;
		@(posedge clk);
		shapes_loaded++;
	endtask

	task automatic send_pixel(pixel_t p, logic typed, avg_t want);
		bit closed;
		avg_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		pixel_x <= p.x;
		pixel_y <= p.y;
		pixel_red <= p.red;
		pixel_green <= p.green;
		pixel_blue <= p.blue;
		last_pixel <= p.last;
		do @(posedge clk); while (full);
		absorb_pixel(p, closed, res);
		if (closed)
			expected_avgs.push_back(typed ? want : res);
		pixels_sent++;
	endtask

	task automatic run_images(int n_items, int max_len);
		int len, sent;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(max_len, 1);
			for (int k = 0; k < len; k++)
				send_pixel(random_pixel(k == len - 1), 1'b0, '0);
			sent += len;
		end
	endtask

	// stop offering, let every average come back and the pipeline empty out
	task automatic finish_phase();
		push <= 1'b0;
		while (expected_avgs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// result side: accept, compare against the oldest prediction, pick next pop
	always @(posedge clk) begin
		avg_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_avgs.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual %0d/%0d/%0d count %0d",
						$time, avg_red, avg_green, avg_blue, covered_count);
					errors++;
				end else begin
					want = expected_avgs.pop_front();
					check_field("avg_red", want.red, avg_red);
					check_field("avg_green", want.green, avg_green);
					check_field("avg_blue", want.blue, avg_blue);
					check_field("covered_count", want.count, covered_count);
					check_field("none_covered", want.none, none_covered);
					averages_checked++;
				end
			end
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_V0X;
		cfg_data <= '0;
		push <= 1'b0;
		pixel_x <= '0;
		pixel_y <= '0;
		pixel_red <= '0;
		pixel_green <= '0;
		pixel_blue <= '0;
		last_pixel <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_shape = 0;
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].shape_sel != cur_shape) begin
				finish_phase();
				load_shape(DIR_SHAPES[DIRECTED[i].shape_sel]);
				cur_shape = DIRECTED[i].shape_sel;
			end
			send_pixel(DIRECTED[i].pix, DIRECTED[i].typed, DIRECTED[i].want);
		end
		finish_phase();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph < 4) begin
				send_idle_pct = 36;
				recv_idle_pct = 45;
			end else if (ph < 8) begin
				send_idle_pct = 45;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			load_shape(random_shape());
			run_images(PHASE_ITEMS, $urandom_range(1) ? 6 : 30);
			finish_phase();
			if (ph == 8) begin
				// short images pile up behind a stalled receiver until full rises
				hold_request = 1'b1;
				run_images(PRESSURE_ITEMS, 3);
				finish_phase();
			end
		end

		$display("sent %0d pixels across %0d triangle settings, %0d image averages checked",
			pixels_sent, shapes_loaded, averages_checked);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[triangle_coverage_average_color.f]
rtl/tcac_pkg.sv
rtl/tcac_front.sv
rtl/tcac_queue.sv
rtl/tcac_divider.sv
rtl/triangle_coverage_average_color.sv
tb/sv/triangle_coverage_average_color_tb.sv
